@@ design/gdi_pkg.sv @@
// Shared types, constants and table functions of the Gregorian date info pipeline.
package gdi_pkg;

    // Field widths of the date.
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;

    // Shifted years reach 16383 + 400 and need one bit more than the year.
    localparam int YS_W = YEAR_W + 1;

    // Division by 100 as a multiplication by a reciprocal and a shift.
    // The product is exact for every dividend below 43690.
    localparam int             DIV100_SHIFT = 21;
    localparam logic [14:0]    DIV100_MUL   = 15'd20972;
    localparam logic [YS_W-1:0] YEAR_OFFSET = 15'd400;
    localparam logic [7:0]     CENTURY      = 8'd100;

    // Month and weekday codes.
    localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
    localparam logic [MONTH_W-1:0] MARCH    = 4'd3;
    localparam logic [2:0]         FRIDAY   = 3'd5;
    localparam logic [2:0]         SATURDAY = 3'd6;

    localparam logic [8:0] COMMON_YEAR_LEN = 9'd365;
    localparam logic [8:0] LEAP_YEAR_LEN   = 9'd366;
    localparam logic [4:0] LONG_MONTH_LEN  = 5'd31;

    // Register between the first and second stage.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YS_W-1:0]    ys;
        logic [MONTH_W-1:0] ms;
        logic [28:0]        prod_y;
        logic [29:0]        prod_s;
    } t_stage1;

    // Register between the second and third stage.
    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               leap;
        logic [YS_W-1:0]    wsum;
    } t_stage2;

    // One result beat.
    typedef struct packed {
        logic [2:0] weekday;
        logic       leap_flag;
        logic [4:0] month_length;
        logic       weekend_flag;
        logic       business_flag;
        logic       week_end_flag;
        logic [2:0] days_to_week_end;
        logic [4:0] days_to_month_end;
        logic [8:0] day_of_year;
        logic [8:0] days_to_year_end;
    } t_result;

    // floor(31 * ms / 12) for the shifted month 1..13.
    function automatic logic [5:0] month_offset(input logic [MONTH_W-1:0] ms);
        logic [5:0] v;
        unique case (ms)
            4'd1:    v = 6'd2;
            4'd2:    v = 6'd5;
            4'd3:    v = 6'd7;
            4'd4:    v = 6'd10;
            4'd5:    v = 6'd12;
            4'd6:    v = 6'd15;
            4'd7:    v = 6'd18;
            4'd8:    v = 6'd20;
            4'd9:    v = 6'd23;
            4'd10:   v = 6'd25;
            4'd11:   v = 6'd28;
            4'd12:   v = 6'd31;
            4'd13:   v = 6'd33;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

    // Month length in a common year; zero for a month code out of range.
    function automatic logic [4:0] base_month_len(input logic [MONTH_W-1:0] m);
        logic [4:0] v;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   v = 5'd30;
            4'd2:                                      v = 5'd28;
            default:                                   v = 5'd0;
        endcase
        return v;
    endfunction

    // Days of all earlier months in a common year.
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] v;
        unique case (m)
            4'd0, 4'd1: v = 9'd0;
            4'd2:       v = 9'd31;
            4'd3:       v = 9'd59;
            4'd4:       v = 9'd90;
            4'd5:       v = 9'd120;
            4'd6:       v = 9'd151;
            4'd7:       v = 9'd181;
            4'd8:       v = 9'd212;
            4'd9:       v = 9'd243;
            4'd10:      v = 9'd273;
            4'd11:      v = 9'd304;
            4'd12:      v = 9'd334;
            default:    v = 9'd365;
        endcase
        return v;
    endfunction

    // Remainder by 7: octal digits are summed since 8 is 1 modulo 7.
    function automatic logic [2:0] mod7(input logic [YS_W-1:0] s);
        logic [5:0] dsum;
        logic [3:0] fold;
        logic [3:0] r;
        dsum = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9]) + 6'(s[14:12]);
        fold = 4'(dsum[5:3]) + 4'(dsum[2:0]);
        r    = (fold >= 4'd7) ? fold - 4'd7 : fold;
        return r[2:0];
    endfunction

endpackage

@@ design/gdi_in_if.sv @@
// Date input channel: valid, ready and the date fields.
interface gdi_in_if;
    logic        valid;
    logic        ready;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;

    modport source (output valid, output year, output month, output day, input ready);
    modport sink   (input valid, input year, input month, input day, output ready);
endinterface

@@ design/gdi_out_if.sv @@
// Result output channel: valid, ready and the calendar facts.
interface gdi_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] weekday;
    logic       leap_flag;
    logic [4:0] month_length;
    logic       weekend_flag;
    logic       business_flag;
    logic       week_end_flag;
    logic [2:0] days_to_week_end;
    logic [4:0] days_to_month_end;
    logic [8:0] day_of_year;
    logic [8:0] days_to_year_end;

    modport source (
        output valid, output weekday, output leap_flag, output month_length,
        output weekend_flag, output business_flag, output week_end_flag,
        output days_to_week_end, output days_to_month_end, output day_of_year,
        output days_to_year_end, input ready
    );
    modport sink (
        input valid, input weekday, input leap_flag, input month_length,
        input weekend_flag, input business_flag, input week_end_flag,
        input days_to_week_end, input days_to_month_end, input day_of_year,
        input days_to_year_end, output ready
    );
endinterface

@@ design/gdi_div_stage.sv @@
// First stage: year shift, shifted month and the reciprocal products for division by 100.
module gdi_div_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [13:0]           i_year,
    input  logic [3:0]            i_month,
    input  logic [4:0]            i_day,
    input  logic                  i_ready,
    output logic                  o_ready,
    output logic                  o_valid,
    output gdi_pkg::t_stage1      o_data
);
    import gdi_pkg::*;

    logic    r_valid;
    t_stage1 r_data;
    t_stage1 n_data;
    logic    shift;

    // January and February count as months of the year before.
    always_comb begin
        shift         = (i_month <= FEBRUARY);
        n_data.year   = i_year;
        n_data.month  = i_month;
        n_data.day    = i_day;
        n_data.ys     = YS_W'(i_year) + YEAR_OFFSET - YS_W'(shift);
        n_data.ms     = shift ? i_month + 4'd10 : i_month - 4'd2;
        n_data.prod_y = 29'(i_year) * 29'(DIV100_MUL);
        n_data.prod_s = 30'(n_data.ys) * 30'(DIV100_MUL);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Stage register; it loads whenever the next stage frees it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule

@@ design/gdi_sum_stage.sv @@
// Second stage: leap-year test and the weekday sum before reduction by 7.
module gdi_sum_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  gdi_pkg::t_stage1      i_data,
    input  logic                  i_ready,
    output logic                  o_ready,
    output logic                  o_valid,
    output gdi_pkg::t_stage2      o_data
);
    import gdi_pkg::*;

    logic        r_valid;
    t_stage2     r_data;
    t_stage2     n_data;
    logic [7:0]  q100_y;
    logic [8:0]  q100_s;
    logic [13:0] cent_y;
    logic        div100;

    always_comb begin
        // Quotients by 100 from the reciprocal products.
        q100_y = i_data.prod_y[28:DIV100_SHIFT];
        q100_s = i_data.prod_s[29:DIV100_SHIFT];
        cent_y = 14'(q100_y) * 14'(CENTURY);
        div100 = (cent_y == i_data.year);

        // Divisible by 400 means a whole century whose count is a multiple of 4.
        n_data.leap  = ((i_data.year[1:0] == 2'd0) && !div100)
                    || (div100 && (q100_y[1:0] == 2'd0));
        n_data.month = i_data.month;
        n_data.day   = i_data.day;

        // d + ys + ys/4 - ys/100 + ys/400 + floor(31 * ms / 12).
        n_data.wsum = YS_W'(i_data.day) + i_data.ys + (i_data.ys >> 2)
                    + YS_W'(q100_s >> 2) + YS_W'(month_offset(i_data.ms))
                    - YS_W'(q100_s);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule

@@ design/gdi_out_stage.sv @@
// Third stage: weekday, its flags, month and year counts, and the output register.
module gdi_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  gdi_pkg::t_stage2      i_data,
    input  logic                  i_ready,
    output logic                  o_ready,
    output logic                  o_valid,
    output gdi_pkg::t_result      o_data
);
    import gdi_pkg::*;

    logic       r_valid;
    t_result    r_data;
    t_result    n_data;
    logic [2:0] wd;
    logic [4:0] mlen;
    logic [5:0] to_mend;
    logic [8:0] doy;
    logic [8:0] ylen;

    always_comb begin
        // Weekday and the flags that follow from it.
        wd                      = mod7(i_data.wsum);
        n_data.weekday          = wd;
        n_data.weekend_flag     = (wd == FRIDAY) || (wd == SATURDAY);
        n_data.business_flag    = (wd < FRIDAY);
        n_data.week_end_flag    = (wd == SATURDAY);
        n_data.days_to_week_end = SATURDAY - wd;
        n_data.leap_flag        = i_data.leap;

        // Month length, with the leap day in February.
        mlen = base_month_len(i_data.month)
             + 5'(i_data.leap && (i_data.month == FEBRUARY));
        n_data.month_length = mlen;

        // Inclusive days to month end, one past the end, saturated at a long month.
        to_mend = (5'(i_data.day) < mlen) ? 6'(mlen) - 6'(i_data.day) + 6'd1 : 6'd1;
        n_data.days_to_month_end = (to_mend > 6'(LONG_MONTH_LEN)) ? LONG_MONTH_LEN
                                                                  : to_mend[4:0];

        // Day of year; every month from March on has the leap day behind it.
        doy = days_before(i_data.month) + 9'(i_data.day)
            + 9'(i_data.leap && (i_data.month >= MARCH));
        n_data.day_of_year = doy;
        ylen = i_data.leap ? LEAP_YEAR_LEN : COMMON_YEAR_LEN;
        n_data.days_to_year_end = (doy < ylen) ? ylen - doy : 9'd0;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Output register; holds the beat while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule

@@ design/gregorian_date_info.sv @@
// Top level of the Gregorian date info pipeline.
//
//  Channel   Direction  Beat contents
//  i_date    in         year, month, day
//  o_info    out        weekday, leap and week flags, month and year day counts
//
// Three register stages: reciprocal products, leap test and weekday sum,
// then reduction by 7 and the day counts into the output register.
// A date is accepted every cycle unless a sink stall has filled the pipeline.
// The synchronous active-low reset clears only the stage valid bits.
// A stage loads when it is empty or its successor moves, so a stall at the
// sink fills the pipeline up and then holds i_date.ready low.
module gregorian_date_info (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gdi_in_if.sink    i_date,
    gdi_out_if.source o_info
);
    import gdi_pkg::*;

    logic    s1_valid;
    logic    s1_ready;
    t_stage1 s1_data;
    logic    s2_valid;
    logic    s2_ready;
    t_stage2 s2_data;
    t_result res;

    gdi_div_stage u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_date.valid),
        .i_year  (i_date.year),
        .i_month (i_date.month),
        .i_day   (i_date.day),
        .i_ready (s1_ready),
        .o_ready (i_date.ready),
        .o_valid (s1_valid),
        .o_data  (s1_data)
    );

    gdi_sum_stage u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .i_ready (s2_ready),
        .o_ready (s1_ready),
        .o_valid (s2_valid),
        .o_data  (s2_data)
    );

    gdi_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_data  (s2_data),
        .i_ready (o_info.ready),
        .o_ready (s2_ready),
        .o_valid (o_info.valid),
        .o_data  (res)
    );

    // Result beat onto the output channel.
    assign o_info.weekday           = res.weekday;
    assign o_info.leap_flag         = res.leap_flag;
    assign o_info.month_length      = res.month_length;
    assign o_info.weekend_flag      = res.weekend_flag;
    assign o_info.business_flag     = res.business_flag;
    assign o_info.week_end_flag     = res.week_end_flag;
    assign o_info.days_to_week_end  = res.days_to_week_end;
    assign o_info.days_to_month_end = res.days_to_month_end;
    assign o_info.day_of_year       = res.day_of_year;
    assign o_info.days_to_year_end  = res.days_to_year_end;
endmodule
